@@ sv/bve_pkg.sv @@
// ----------------------------------------------------------------------------
// bve_pkg: shared types and constants of the bit vector engine
// Operation codes, transaction payload structs and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package bve_pkg;

  // Default capacity of the vector in bits.
  localparam int MAX_BITS_DEF = 256;

  // Bits of one storage word, and how a bit index splits into word and offset.
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int WORD_MASK  = 'h3F;

  // Width of the common compare domain for indexes and lengths (holds 4096).
  localparam int CMP_W = 13;

  // Field widths of the transactions.
  localparam int FUNC_W   = 4;
  localparam int BIDX_W   = 12;
  localparam int SHAMT_W  = 12;
  localparam int NLEN_W   = 9;
  localparam int WIDX_W   = 2;
  localparam int SLEN_W   = 9;
  localparam int LENOUT_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET     = 4'd0,
    FUNC_CLEAR   = 4'd1,
    FUNC_TEST    = 4'd2,
    FUNC_SHUP    = 4'd3,
    FUNC_SHDN    = 4'd4,
    FUNC_AND     = 4'd5,
    FUNC_OR      = 4'd6,
    FUNC_XOR     = 4'd7,
    FUNC_ZERO    = 4'd8,
    FUNC_FILL    = 4'd9,
    FUNC_RESIZE  = 4'd10
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [BIDX_W-1:0]    bit_index;
    logic [SHAMT_W-1:0]   shift_amount;
    logic [NLEN_W-1:0]    new_length;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_value;
    logic [SLEN_W-1:0]    source_length;
  } op_t;

  typedef struct packed {
    logic                bit_value;
    logic                all_clear;
    logic                all_set;
    logic [LENOUT_W-1:0] length_now;
    logic                status;
  } res_t;

endpackage

`default_nettype wire

@@ sv/bve_in_reg.sv @@
// ----------------------------------------------------------------------------
// bve_in_reg: input register of the bit vector engine
// Captures one operation transaction and holds it while the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bve_in_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              stall_o,
  input  wire bve_pkg::op_t op_i,
  input  wire logic         hold_i,
  output logic              valid_o,
  output bve_pkg::op_t      op_o
);

  logic         valid_q;
  logic         valid_d;
  bve_pkg::op_t op_q;

  // The held operation can only leave when the result register can take it.
  assign stall_o = valid_q & hold_i;
  assign valid_d = stall_o ? valid_q : valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      op_q <= op_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

`default_nettype wire

@@ sv/bve_core.sv @@
// ----------------------------------------------------------------------------
// bve_core: vector state and single-pass operation logic
// Holds the bit store and length, and applies one operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bve_core #(
  parameter int MAX_BITS = bve_pkg::MAX_BITS_DEF,
  localparam int NumWords = (MAX_BITS + bve_pkg::WORD_BITS - 1) / bve_pkg::WORD_BITS,
  localparam int VecW     = NumWords * bve_pkg::WORD_BITS,
  localparam int LenW     = $clog2(MAX_BITS + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire bve_pkg::op_t op_i,
  output bve_pkg::res_t     res_o,
  output logic [LenW-1:0]   len_o,
  output logic [VecW-1:0]   store_o
);

  localparam int IdxW = $clog2(VecW);
  localparam int WB   = bve_pkg::WORD_BITS;
  localparam logic [bve_pkg::CMP_W-1:0] MaxCmp = bve_pkg::CMP_W'(MAX_BITS);

  logic [VecW-1:0]           store_q;
  logic [VecW-1:0]           store_d;
  logic [VecW-1:0]           store_new;
  logic [LenW-1:0]           len_q;
  logic [LenW-1:0]           len_d;
  logic [VecW-1:0]           old_mask;
  logic [VecW-1:0]           new_mask;
  logic [VecW-1:0]           src_mask;
  logic [VecW-1:0]           bit_onehot;
  logic [IdxW-1:0]           bit_pos;
  logic [bve_pkg::CMP_W-1:0] idx_cmp;
  logic [bve_pkg::CMP_W-1:0] len_cmp;
  logic [bve_pkg::CMP_W-1:0] nlen_cmp;
  logic [bve_pkg::CMP_W-1:0] len_out_cmp;
  logic                      idx_ok;
  logic [LenW-1:0]           grown_len;
  logic                      bitv;
  logic                      status;
  logic [WB-1:0]             word_old;
  logic [WB-1:0]             word_src;

  assign idx_cmp  = bve_pkg::CMP_W'(op_i.bit_index);
  assign len_cmp  = bve_pkg::CMP_W'(len_q);
  assign nlen_cmp = bve_pkg::CMP_W'(op_i.new_length);
  assign idx_ok   = idx_cmp < MaxCmp;
  assign bit_pos  = IdxW'(op_i.bit_index);

  // A bit access beyond the length grows the length to cover it.
  assign grown_len = (idx_cmp >= len_cmp) ? LenW'(idx_cmp + 1'b1) : len_q;

  assign old_mask   = ~({VecW{1'b1}} << len_q);
  assign src_mask   = ~({VecW{1'b1}} << op_i.source_length);
  assign bit_onehot = VecW'(1) << bit_pos;

  always_comb begin
    store_d  = store_q;
    len_d    = len_q;
    bitv     = 1'b0;
    status   = 1'b0;
    word_old = '0;
    word_src = '0;
    case (op_i.func)
      bve_pkg::FUNC_SET: begin
        if (!idx_ok) begin
          status = 1'b1;
        end else begin
          len_d   = grown_len;
          store_d = store_q | bit_onehot;
        end
      end
      bve_pkg::FUNC_CLEAR: begin
        if (!idx_ok) begin
          status = 1'b1;
        end else begin
          len_d   = grown_len;
          store_d = store_q & ~bit_onehot;
        end
      end
      bve_pkg::FUNC_TEST: begin
        if (!idx_ok) begin
          status = 1'b1;
        end else begin
          len_d = grown_len;
          // Bits at or above the old length are always zero.
          bitv  = store_q[bit_pos];
        end
      end
      bve_pkg::FUNC_SHUP: begin
        store_d = store_q << op_i.shift_amount;
      end
      bve_pkg::FUNC_SHDN: begin
        store_d = store_q >> op_i.shift_amount;
      end
      bve_pkg::FUNC_AND, bve_pkg::FUNC_OR, bve_pkg::FUNC_XOR: begin
        if (int'(op_i.word_index) >= NumWords) begin
          status = 1'b1;
        end else begin
          for (int w = 0; w < NumWords; w++) begin
            if (int'(op_i.word_index) == w) begin
              word_old = store_q[w*WB +: WB];
              word_src = op_i.word_value & src_mask[w*WB +: WB];
              if (op_i.func == bve_pkg::FUNC_AND) begin
                store_d[w*WB +: WB] = word_old & (word_src | ~src_mask[w*WB +: WB]);
              end else if (op_i.func == bve_pkg::FUNC_OR) begin
                store_d[w*WB +: WB] = word_old | word_src;
              end else begin
                store_d[w*WB +: WB] = word_old ^ word_src;
              end
            end
          end
        end
      end
      bve_pkg::FUNC_ZERO: begin
        store_d = '0;
      end
      bve_pkg::FUNC_FILL: begin
        store_d = old_mask;
      end
      bve_pkg::FUNC_RESIZE: begin
        if (nlen_cmp > MaxCmp) begin
          status = 1'b1;
        end else begin
          len_d = LenW'(nlen_cmp);
        end
      end
      default: begin
        store_d = store_q;
      end
    endcase
  end

  // Every operation ends with the store trimmed to the resulting length.
  assign new_mask    = ~({VecW{1'b1}} << len_d);
  assign store_new   = store_d & new_mask;
  assign len_out_cmp = bve_pkg::CMP_W'(len_d);

  always_comb begin
    res_o.bit_value  = bitv;
    res_o.all_clear  = ~|store_new;
    res_o.all_set    = &(store_new | ~new_mask);
    res_o.length_now = len_out_cmp[bve_pkg::LENOUT_W-1:0];
    res_o.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      store_q <= store_new;
      len_q   <= len_d;
    end
  end

  assign len_o   = len_q;
  assign store_o = store_q;

endmodule

`default_nettype wire

@@ sv/bve_out_reg.sv @@
// ----------------------------------------------------------------------------
// bve_out_reg: result register of the bit vector engine
// Holds one result transaction until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bve_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire bve_pkg::res_t res_i,
  input  wire logic          stall_i,
  output logic               hold_o,
  output logic               valid_o,
  output bve_pkg::res_t      res_o
);

  logic          valid_q;
  logic          valid_d;
  bve_pkg::res_t res_q;

  assign hold_o = valid_q & stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ sv/bit_vector_engine.sv @@
// ----------------------------------------------------------------------------
// bit_vector_engine: variable-length bit vector with one operation per transaction
// An accepted operation reaches its result through the input register, then the
// result register. Throughput: one transaction per cycle while the result side
// does not stall; the bit store is updated between the two registers.
// Reset: the store is cleared, the length is zero and both registers are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_vector_engine #(
  parameter int MAX_BITS = bve_pkg::MAX_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bve_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [bve_pkg::BIDX_W-1:0]    bit_index_i,
  input  wire logic [bve_pkg::SHAMT_W-1:0]   shift_amount_i,
  input  wire logic [bve_pkg::NLEN_W-1:0]    new_length_i,
  input  wire logic [bve_pkg::WIDX_W-1:0]    word_index_i,
  input  wire logic [bve_pkg::WORD_BITS-1:0] word_value_i,
  input  wire logic [bve_pkg::SLEN_W-1:0]    source_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               bit_value_o,
  output logic                               all_clear_o,
  output logic                               all_set_o,
  output logic [bve_pkg::LENOUT_W-1:0]       length_now_o,
  output logic                               status_o
);

  localparam int NumWords = (MAX_BITS + bve_pkg::WORD_BITS - 1) / bve_pkg::WORD_BITS;
  localparam int VecW     = NumWords * bve_pkg::WORD_BITS;
  localparam int LenW     = $clog2(MAX_BITS + 1);

  bve_pkg::op_t    in_op;
  bve_pkg::op_t    s1_op;
  bve_pkg::res_t   core_res;
  bve_pkg::res_t   out_res;
  logic            s1_valid;
  logic            out_hold;
  logic            s1_fire;
  logic [LenW-1:0] core_len;
  logic [VecW-1:0] core_store;

  always_comb begin
    in_op.func          = bve_pkg::func_e'(func_i);
    in_op.bit_index     = bit_index_i;
    in_op.shift_amount  = shift_amount_i;
    in_op.new_length    = new_length_i;
    in_op.word_index    = word_index_i;
    in_op.word_value    = word_value_i;
    in_op.source_length = source_length_i;
  end

  bve_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .op_i    (in_op),
    .hold_i  (out_hold),
    .valid_o (s1_valid),
    .op_o    (s1_op)
  );

  // The state advances exactly when an operation moves into the result register.
  assign s1_fire = s1_valid & ~out_hold;

  bve_core #(
    .MAX_BITS (MAX_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .op_i    (s1_op),
    .res_o   (core_res),
    .len_o   (core_len),
    .store_o (core_store)
  );

  bve_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_fire),
    .res_i   (core_res),
    .stall_i (out_stall_i),
    .hold_o  (out_hold),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign bit_value_o  = out_res.bit_value;
  assign all_clear_o  = out_res.all_clear;
  assign all_set_o    = out_res.all_set;
  assign length_now_o = out_res.length_now;
  assign status_o     = out_res.status;

  // Bits at or above the current length are never set.
  a_tail_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_store & ({VecW{1'b1}} << core_len)) == '0)
    else $error("bit store holds a set bit at or above the length");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(core_len) <= MAX_BITS)
    else $error("vector length beyond capacity");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(core_len) && $stable(core_store))
    else $error("vector state changed without a transaction");

  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_fire))
    else $error("result appeared without a processed transaction");

endmodule

`default_nettype wire
